FILE: hw/rtl/pngsu_pkg.sv
// pngsu_pkg: shared types, constants and helpers of the png scanline unfilter
// used by every rtl file of the block but pngsu_ram; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package pngsu_pkg;

  // sizes
  localparam int LINE_BYTES      = 8192;
  localparam int MAX_PIXEL_BYTES = 8;
  localparam int BPP_W           = 4;
  localparam int WIDTH_W         = 14;
  localparam int HEIGHT_W        = 16;
  localparam int CFG_DATA_W      = 16;
  localparam int CFG_IDX_W       = 2;
  localparam int ADDR_W          = $clog2(LINE_BYTES);
  localparam int MAX_ROW_LEN     = ((2 ** WIDTH_W) - 1) * MAX_PIXEL_BYTES;
  localparam int POS_W           = $clog2(MAX_ROW_LEN + 1);
  localparam int HIST_IDX_W      = ($clog2(MAX_PIXEL_BYTES) > 0) ? $clog2(MAX_PIXEL_BYTES) : 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BPP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

  // filter types
  localparam logic [2:0] FILT_NONE  = 3'd0;
  localparam logic [2:0] FILT_SUB   = 3'd1;
  localparam logic [2:0] FILT_UP    = 3'd2;
  localparam logic [2:0] FILT_AVG   = 3'd3;
  localparam logic [2:0] FILT_PAETH = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_TYPE = 2'd1;
  localparam logic [1:0] ST_TOO_LONG = 2'd2;

  // one classified item, front to back
  typedef struct packed {
    logic [7:0]        data;
    logic              is_type;
    logic              do_data;
    logic              in_store;
    logic              first_row;
    logic [2:0]        filter;
    logic [ADDR_W-1:0] addr;
    logic [1:0]        status;
    logic              row_end;
    logic              img_end;
  } item_t;

  // zero treated as one, large values saturated
  function automatic logic [BPP_W-1:0] bpp_eff(input logic [BPP_W-1:0] bpp);
    logic [BPP_W-1:0] res;
    res = bpp;
    if (bpp == '0) begin
      res = BPP_W'(1);
    end else if (bpp > BPP_W'(MAX_PIXEL_BYTES)) begin
      res = BPP_W'(MAX_PIXEL_BYTES);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/pngsu_ram.sv
// pngsu_ram: generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module pngsu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, held while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hw/rtl/pngsu_front.sv
// pngsu_front: accepts stream bytes, tracks position, row and error, classifies each item
// depends on pngsu_pkg
`timescale 1ns / 1ps
`default_nettype none

module pngsu_front
  import pngsu_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                accept_i,
  input  wire logic [7:0]          data_byte_i,
  input  wire logic [BPP_W-1:0]    bpp_i,
  input  wire logic [WIDTH_W-1:0]  width_i,
  input  wire logic [HEIGHT_W-1:0] height_i,
  output item_t                    item_o
);

  logic [POS_W-1:0]            pos_q, pos_d;
  logic [HEIGHT_W-1:0]         row_q, row_d;
  logic [2:0]                  filt_q, filt_d;
  logic                        first_q, first_d;
  logic [1:0]                  err_q, err_d;

  logic [WIDTH_W+BPP_W-1:0]    prod;
  logic [POS_W-1:0]            row_len;
  logic [HEIGHT_W-1:0]         height_eff;
  logic                        is_type;
  logic                        row_end;
  logic                        img_end;
  logic [1:0]                  err_item;
  logic [POS_W-1:0]            idx;

  // row geometry
  assign prod       = width_i * bpp_i;
  assign row_len    = prod[POS_W-1:0];
  assign height_eff = (height_i == '0) ? HEIGHT_W'(1) : height_i;

  // classification of the offered byte
  assign is_type = (pos_q == '0);
  assign row_end = (pos_q >= row_len);
  assign img_end = row_end && (row_q >= height_eff - HEIGHT_W'(1));
  assign idx     = pos_q - POS_W'(1);

  // error and filter update at a type byte
  always_comb begin
    err_item = err_q;
    filt_d   = filt_q;
    if (is_type) begin
      if (err_q == ST_OK) begin
        if (row_len > POS_W'(LINE_BYTES)) begin
          err_item = ST_TOO_LONG;
        end else if (data_byte_i > 8'd4) begin
          err_item = ST_BAD_TYPE;
        end
      end
      filt_d = (data_byte_i <= 8'd4) ? data_byte_i[2:0] : FILT_NONE;
    end
  end

  // counters and sticky state
  always_comb begin
    pos_d   = pos_q + POS_W'(1);
    row_d   = row_q;
    first_d = first_q;
    err_d   = err_item;
    if (row_end) begin
      pos_d   = '0;
      first_d = 1'b0;
      row_d   = row_q + HEIGHT_W'(1);
      if (img_end) begin
        row_d   = '0;
        first_d = 1'b1;
        err_d   = ST_OK;
      end
    end
  end

  // item to the back part
  always_comb begin
    item_o.data      = data_byte_i;
    item_o.is_type   = is_type;
    item_o.do_data   = !is_type && (err_q == ST_OK);
    item_o.in_store  = (idx < POS_W'(LINE_BYTES));
    item_o.first_row = first_q;
    item_o.filter    = filt_d;
    item_o.addr      = idx[ADDR_W-1:0];
    item_o.status    = err_item;
    item_o.row_end   = row_end;
    item_o.img_end   = img_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      row_q   <= '0;
      filt_q  <= FILT_NONE;
      first_q <= 1'b1;
      err_q   <= ST_OK;
    end else if (accept_i) begin
      pos_q   <= pos_d;
      row_q   <= row_d;
      filt_q  <= filt_d;
      first_q <= first_d;
      err_q   <= err_d;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/pngsu_fifo.sv
// pngsu_fifo: two-entry item queue between the front and back parts
// depends on pngsu_pkg
`timescale 1ns / 1ps
`default_nettype none

module pngsu_fifo
  import pngsu_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire item_t item_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output logic       valid_o,
  output item_t      item_o
);

  item_t      ent_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = ent_q[rd_q];

  // pointers and fill level
  always_comb begin
    wr_d  = push_i ? !wr_q : wr_q;
    rd_d  = pop_i ? !rd_q : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/pngsu_back.sv
// pngsu_back: reconstructs bytes from the line store and left history, holds the output register
// depends on pngsu_pkg and pngsu_ram
`timescale 1ns / 1ps
`default_nettype none

module pngsu_back
  import pngsu_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [BPP_W-1:0] bpp_i,
  input  wire logic             fifo_valid_i,
  input  wire item_t            fifo_item_i,
  output logic                  fifo_pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [7:0]            pixel_byte_o,
  output logic                  is_type_byte_o,
  output logic [1:0]            status_o,
  output logic                  row_end_o,
  output logic                  image_end_o
);

  item_t                  cur_q;
  logic                   cur_vld_q, cur_vld_d;
  logic                   out_vld_q, out_vld_d;
  logic [7:0]             pix_q;
  logic                   type_q;
  logic [1:0]             stat_q;
  logic                   rend_q;
  logic                   iend_q;
  logic [7:0]             left_q [MAX_PIXEL_BYTES];
  logic [7:0]             ul_q   [MAX_PIXEL_BYTES];

  logic                   out_free;
  logic                   adv;
  logic                   pop;
  logic [7:0]             rdata;
  logic [BPP_W-1:0]       bpp_m1;
  logic [HIST_IDX_W-1:0]  hidx;
  logic [7:0]             a, b, c;
  logic [8:0]             avg_sum;
  logic signed [10:0]     da, db, dc;
  logic [9:0]             pa, pb, pc;
  logic [7:0]             paeth;
  logic [7:0]             pred;
  logic [7:0]             pixel;

  // handshake between stages
  assign out_free   = !out_vld_q || out_ready_i;
  assign adv        = cur_vld_q && out_free;
  assign pop        = fifo_valid_i && (!cur_vld_q || adv);
  assign fifo_pop_o = pop;

  // previous row store, read as the item enters, written as it leaves
  pngsu_ram #(
    .WIDTH (8),
    .DEPTH (LINE_BYTES)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (adv && cur_q.do_data && cur_q.in_store),
    .waddr_i (cur_q.addr),
    .wdata_i (pixel),
    .re_i    (pop),
    .raddr_i (fifo_item_i.addr),
    .rdata_o (rdata)
  );

  // neighbours
  assign bpp_m1 = bpp_i - BPP_W'(1);
  assign hidx   = bpp_m1[HIST_IDX_W-1:0];
  assign a      = left_q[hidx];
  assign b      = (!cur_q.first_row && cur_q.in_store) ? rdata : 8'd0;
  assign c      = !cur_q.first_row ? ul_q[hidx] : 8'd0;

  // paeth predictor, ties to left then above
  always_comb begin
    da    = $signed({3'b000, b}) - $signed({3'b000, c});
    db    = $signed({3'b000, a}) - $signed({3'b000, c});
    dc    = $signed({3'b000, a}) + $signed({3'b000, b}) - $signed({2'b00, c, 1'b0});
    pa    = da[10] ? 10'(-da) : da[9:0];
    pb    = db[10] ? 10'(-db) : db[9:0];
    pc    = dc[10] ? 10'(-dc) : dc[9:0];
    paeth = c;
    if (pa <= pb && pa <= pc) begin
      paeth = a;
    end else if (pb <= pc) begin
      paeth = b;
    end
  end

  // prediction by filter type
  assign avg_sum = {1'b0, a} + {1'b0, b};
  always_comb begin
    case (cur_q.filter)
      FILT_SUB:   pred = a;
      FILT_UP:    pred = b;
      FILT_AVG:   pred = avg_sum[8:1];
      FILT_PAETH: pred = paeth;
      default:    pred = 8'd0;
    endcase
  end

  assign pixel = cur_q.do_data ? (cur_q.data + pred) : 8'd0;

  // valid flags
  always_comb begin
    cur_vld_d = cur_vld_q;
    if (pop) begin
      cur_vld_d = 1'b1;
    end else if (adv) begin
      cur_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (adv) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      cur_vld_q <= cur_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // item register
  always_ff @(posedge clk_i) begin
    if (pop) begin
      cur_q <= fifo_item_i;
    end
  end

  // left and upper-left history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
        left_q[i] <= 8'd0;
        ul_q[i]   <= 8'd0;
      end
    end else if (adv) begin
      if (cur_q.is_type) begin
        for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
          left_q[i] <= 8'd0;
          ul_q[i]   <= 8'd0;
        end
      end else if (cur_q.do_data) begin
        for (int i = MAX_PIXEL_BYTES - 1; i > 0; i--) begin
          left_q[i] <= left_q[i-1];
          ul_q[i]   <= ul_q[i-1];
        end
        left_q[0] <= pixel;
        ul_q[0]   <= b;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (adv) begin
      pix_q  <= pixel;
      type_q <= cur_q.is_type;
      stat_q <= cur_q.status;
      rend_q <= cur_q.row_end;
      iend_q <= cur_q.img_end;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign pixel_byte_o   = pix_q;
  assign is_type_byte_o = type_q;
  assign status_o       = stat_q;
  assign row_end_o      = rend_q;
  assign image_end_o    = iend_q;

endmodule

`default_nettype wire

FILE: hw/rtl/png_scanline_unfilter_core.sv
// png_scanline_unfilter_core: top level, config registers, front, queue and back
// depends on pngsu_pkg, pngsu_front, pngsu_fifo, pngsu_back
// each result passes a queue entry, the item register and the output register
// throughput: one byte per cycle unless the output stalls, set by the left-neighbour loop
// reset: counters, flags and history cleared, config registers set to one; line store
// not cleared, entries are written by each row before the next row reads them
`timescale 1ns / 1ps
`default_nettype none

module png_scanline_unfilter_core
  import pngsu_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [7:0]            data_byte_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [7:0]                 pixel_byte_o,
  output logic                       is_type_byte_o,
  output logic [1:0]                 status_o,
  output logic                       row_end_o,
  output logic                       image_end_o
);

  logic [BPP_W-1:0]    bpp_q;
  logic [WIDTH_W-1:0]  width_q;
  logic [HEIGHT_W-1:0] height_q;
  logic [BPP_W-1:0]    bpp;
  logic                accept;
  logic                fifo_full;
  logic                fifo_valid;
  logic                fifo_pop;
  item_t               front_item;
  item_t               fifo_item;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_q    <= BPP_W'(1);
      width_q  <= WIDTH_W'(1);
      height_q <= HEIGHT_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BPP:    bpp_q    <= cfg_data_i[BPP_W-1:0];
        CFG_WIDTH:  width_q  <= cfg_data_i[WIDTH_W-1:0];
        CFG_HEIGHT: height_q <= cfg_data_i[HEIGHT_W-1:0];
        default:    ;
      endcase
    end
  end

  assign bpp        = bpp_eff(bpp_q);
  assign in_ready_o = !fifo_full;
  assign accept     = in_valid_i && !fifo_full;

  // front: position tracking and classification
  pngsu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .bpp_i       (bpp),
    .width_i     (width_q),
    .height_i    (height_q),
    .item_o      (front_item)
  );

  // item queue
  pngsu_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .item_i  (front_item),
    .full_o  (fifo_full),
    .pop_i   (fifo_pop),
    .valid_o (fifo_valid),
    .item_o  (fifo_item)
  );

  // back: reconstruction and output
  pngsu_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .bpp_i          (bpp),
    .fifo_valid_i   (fifo_valid),
    .fifo_item_i    (fifo_item),
    .fifo_pop_o     (fifo_pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pixel_byte_o   (pixel_byte_o),
    .is_type_byte_o (is_type_byte_o),
    .status_o       (status_o),
    .row_end_o      (row_end_o),
    .image_end_o    (image_end_o)
  );

endmodule

`default_nettype wire

FILE: sim/png_scanline_unfilter_chk.sv
// png_scanline_unfilter_chk: watches the byte and result channels of the unfilter core,
// predicts each result and compares it field by field; depends on pngsu_pkg
`timescale 1ns / 1ps

module png_scanline_unfilter_chk
  import pngsu_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [7:0]            data_byte_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [7:0]            pixel_byte_i,
  input  logic                  is_type_byte_i,
  input  logic [1:0]            status_i,
  input  logic                  row_end_i,
  input  logic                  image_end_i,
  output int                    err_count_o,
  output int                    pending_o
);

  // one predicted result item
  typedef struct packed {
    logic [7:0] pixel;
    logic       is_type;
    logic [1:0] status;
    logic       row_end;
    logic       img_end;
  } pixel_result_t;

  pixel_result_t expected_pixels [$];
  int            fail_cnt = 0;

  // mirrored registers
  logic [BPP_W-1:0]    bpp_reg;
  logic [WIDTH_W-1:0]  width_reg;
  logic [HEIGHT_W-1:0] height_reg;

  // mirrored reconstruction state
  logic [7:0]  line_mem  [LINE_BYTES];
  logic [7:0]  left_hist [MAX_PIXEL_BYTES];
  logic [7:0]  ul_hist   [MAX_PIXEL_BYTES];
  int unsigned col_pos;
  int unsigned row_idx;
  logic [2:0]  cur_filter;
  logic        first_row;
  logic [1:0]  err_code;

  // paeth predictor, ties go to left then above
  function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c);
    int ia, ib, ic, p, pa, pb, pc;
    ia = a;
    ib = b;
    ic = c;
    p  = ia + ib - ic;
    pa = p - ia;
    pb = p - ib;
    pc = p - ic;
    if (pa < 0) pa = -pa;
    if (pb < 0) pb = -pb;
    if (pc < 0) pc = -pc;
    if (pa <= pb && pa <= pc) return a;
    if (pb <= pc) return b;
    return c;
  endfunction

  // reconstruct one byte of the stream and advance the row and image counters
  function automatic pixel_result_t unfilter_byte(input logic [7:0] din);
    pixel_result_t res;
    int unsigned   bpp, row_len, height, idx;
    logic [7:0]    a, b, c, pred;
    logic          in_mem;
    int            i;
    bpp     = (bpp_reg == 0) ? 1 : (bpp_reg > MAX_PIXEL_BYTES) ? MAX_PIXEL_BYTES : bpp_reg;
    row_len = width_reg * bpp;
    height  = (height_reg == 0) ? 1 : height_reg;
    res         = '0;
    res.row_end = (col_pos >= row_len);
    res.img_end = res.row_end && (row_idx >= height - 1);
    if (col_pos == 0) begin
      // filter-type position, first error wins
      res.is_type = 1'b1;
      if (err_code == ST_OK) begin
        if (row_len > LINE_BYTES) begin
          err_code = ST_TOO_LONG;
        end else if (din > FILT_PAETH) begin
          err_code = ST_BAD_TYPE;
        end
      end
      cur_filter = (din <= FILT_PAETH) ? din[2:0] : FILT_NONE;
      left_hist  = '{default: 8'h00};
      ul_hist    = '{default: 8'h00};
    end else if (err_code == ST_OK) begin
      idx    = col_pos - 1;
      in_mem = (idx < LINE_BYTES);
      a      = left_hist[bpp-1];
      b      = (!first_row && in_mem) ? line_mem[idx] : 8'h00;
      c      = !first_row ? ul_hist[bpp-1] : 8'h00;
      case (cur_filter)
        FILT_SUB:   pred = a;
        FILT_UP:    pred = b;
        FILT_AVG:   pred = 8'((9'(a) + 9'(b)) >> 1);
        FILT_PAETH: pred = paeth_pick(a, b, c);
        default:    pred = 8'h00;
      endcase
      res.pixel = din + pred;
      for (i = MAX_PIXEL_BYTES - 1; i > 0; i--) begin
        left_hist[i] = left_hist[i-1];
        ul_hist[i]   = ul_hist[i-1];
      end
      left_hist[0] = res.pixel;
      ul_hist[0]   = b;
      if (in_mem) line_mem[idx] = res.pixel;
    end
    res.status = err_code;
    // row and image bookkeeping
    if (res.row_end) begin
      col_pos   = 0;
      first_row = 1'b0;
      if (res.img_end) begin
        row_idx   = 0;
        first_row = 1'b1;
        err_code  = ST_OK;
      end else begin
        row_idx++;
      end
    end else begin
      col_pos++;
    end
    return res;
  endfunction

  function automatic void check_field(input string what, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      fail_cnt++;
    end
  endfunction

  // result check first, then prediction of a newly accepted item, then register writes
  always @(posedge clk_i or negedge rst_ni) begin
    pixel_result_t want;
    if (!rst_ni) begin
      bpp_reg    = BPP_W'(1);
      width_reg  = WIDTH_W'(1);
      height_reg = HEIGHT_W'(1);
      left_hist  = '{default: 8'h00};
      ul_hist    = '{default: 8'h00};
      col_pos    = 0;
      row_idx    = 0;
      cur_filter = FILT_NONE;
      first_row  = 1'b1;
      err_code   = ST_OK;
      expected_pixels.delete();
      pending_o   <= 0;
      err_count_o <= fail_cnt;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual pixel %02h type %0b",
                   $time, pixel_byte_i, is_type_byte_i);
          fail_cnt++;
        end else begin
          want = expected_pixels.pop_front();
          check_field("pixel_byte", want.pixel, pixel_byte_i);
          check_field("is_type_byte", want.is_type, is_type_byte_i);
          check_field("status", want.status, status_i);
          check_field("row_end", want.row_end, row_end_i);
          check_field("image_end", want.img_end, image_end_i);
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_pixels.push_back(unfilter_byte(data_byte_i));
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_BPP:    bpp_reg    = cfg_data_i[BPP_W-1:0];
          CFG_WIDTH:  width_reg  = cfg_data_i[WIDTH_W-1:0];
          CFG_HEIGHT: height_reg = cfg_data_i[HEIGHT_W-1:0];
          default:    ;
        endcase
      end
      pending_o   <= expected_pixels.size();
      err_count_o <= fail_cnt;
    end
  end

endmodule

FILE: sim/png_scanline_unfilter_core_tb.sv
// png_scanline_unfilter_core_tb: drives bytes and register writes into the unfilter core
// under random idling and gives the verdict; depends on pngsu_pkg and png_scanline_unfilter_chk
`timescale 1ns / 1ps

module png_scanline_unfilter_core_tb;
  import pngsu_pkg::*;

  localparam int CLK_PERIOD    = 20;
  localparam int RESET_CYCLES  = 9;
  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int RANDOM_ITEMS  = 1900;
  localparam int SETTLE_CYCLES = 4;

  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [7:0]            data_byte_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [7:0]            pixel_byte_o;
  logic                  is_type_byte_o;
  logic [1:0]            status_o;
  logic                  row_end_o;
  logic                  image_end_o;

  int          err_count;
  int          pending;
  int unsigned cycle_cnt;
  int unsigned bytes_sent;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  // geometry as last written
  logic [BPP_W-1:0]    geo_bpp;
  logic [WIDTH_W-1:0]  geo_width;
  logic [HEIGHT_W-1:0] geo_height;

  png_scanline_unfilter_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pixel_byte_o   (pixel_byte_o),
    .is_type_byte_o (is_type_byte_o),
    .status_o       (status_o),
    .row_end_o      (row_end_o),
    .image_end_o    (image_end_o)
  );

  png_scanline_unfilter_chk chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pixel_byte_i   (pixel_byte_o),
    .is_type_byte_i (is_type_byte_o),
    .status_i       (status_o),
    .row_end_i      (row_end_o),
    .image_end_i    (image_end_o),
    .err_count_o    (err_count),
    .pending_o      (pending)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // receiver stalls
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // watchdog
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("png_scanline_unfilter_core_tb: done, errors");
    $finish;
  end

  // data bytes lean towards the extremes
  function automatic logic [7:0] rand_data();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 10) return 8'h00;
    if (sel < 20) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // mostly known filter types, now and then an unknown one
  function automatic logic [7:0] rand_filter();
    if ($urandom_range(0, 99) < 92) return 8'($urandom_range(FILT_NONE, FILT_PAETH));
    return 8'($urandom_range(5, 255));
  endfunction

  function automatic int unsigned row_bytes();
    int unsigned bpp;
    bpp = (geo_bpp == 0) ? 1 : (geo_bpp > MAX_PIXEL_BYTES) ? MAX_PIXEL_BYTES : geo_bpp;
    return geo_width * bpp;
  endfunction

  // one item: optional gap, then hold valid until accepted
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
  endtask

  // register write once the block has drained
  task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_geometry(input logic [CFG_DATA_W-1:0] bpp_val,
                              input logic [CFG_DATA_W-1:0] w_val,
                              input logic [CFG_DATA_W-1:0] h_val);
    reg_write(CFG_BPP, bpp_val);
    reg_write(CFG_WIDTH, w_val);
    reg_write(CFG_HEIGHT, h_val);
    geo_bpp    = bpp_val[BPP_W-1:0];
    geo_width  = w_val[WIDTH_W-1:0];
    geo_height = h_val;
  endtask

  task automatic send_row(input logic [7:0] ftype, input int unsigned len);
    send_byte(ftype);
    repeat (len) send_byte(rand_data());
  endtask

  task automatic send_image();
    int unsigned rows, len;
    len  = row_bytes();
    rows = (geo_height == 0) ? 1 : geo_height;
    repeat (rows) send_row(rand_filter(), len);
  endtask

  // whole images only, so the geometry never changes inside one
  task automatic run_random(input int unsigned n_items);
    int unsigned start, sel, bpp_v, w_v, h_v;
    start = bytes_sent;
    while (bytes_sent - start < n_items) begin
      sel   = $urandom_range(0, 99);
      bpp_v = (sel < 10) ? 0 : (sel < 20) ? $urandom_range(9, 15) : $urandom_range(1, 8);
      sel   = $urandom_range(0, 99);
      w_v   = (sel < 8) ? 0 : (sel < 92) ? $urandom_range(1, 6) : $urandom_range(7, 40);
      h_v   = $urandom_range(0, 4);
      // unused upper bits of the write data now and then
      if ($urandom_range(0, 1) == 1) begin
        bpp_v |= $urandom_range(0, 4095) << BPP_W;
        w_v   |= $urandom_range(0, 3) << WIDTH_W;
      end
      if ($urandom_range(0, 9) == 0) begin
        reg_write(CFG_SPARE, CFG_DATA_W'($urandom_range(0, 65535)));
      end
      set_geometry(CFG_DATA_W'(bpp_v), CFG_DATA_W'(w_v), CFG_DATA_W'(h_v));
      repeat ($urandom_range(1, 3)) send_image();
    end
  endtask

  // stimulus and verdict
  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_BPP;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    data_byte_i   = 8'h00;
    bytes_sent    = 0;
    send_idle_pct = 31;
    recv_idle_pct = 55;
    geo_bpp       = BPP_W'(1);
    geo_width     = WIDTH_W'(1);
    geo_height    = HEIGHT_W'(1);
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset geometry: one byte per row, one row per image
    send_byte(8'(FILT_UP));
    send_byte(8'hFF);

    // two-byte pixels, the sub, average and paeth filters over extreme bytes
    set_geometry(16'd2, 16'd2, 16'd3);
    send_byte(8'(FILT_SUB));   send_byte(8'hFF); send_byte(8'h01); send_byte(8'h01);
    send_byte(8'h00);
    send_byte(8'(FILT_AVG));   send_byte(8'hFF); send_byte(8'hFF); send_byte(8'h80);
    send_byte(8'h7F);
    send_byte(8'(FILT_PAETH)); send_byte(8'h00); send_byte(8'hFF); send_byte(8'h01);
    send_byte(8'h80);

    // unknown filter type sticks until the image ends
    set_geometry(16'd1, 16'd1, 16'd2);
    send_byte(8'h05);          send_byte(8'hAA);
    send_byte(8'(FILT_NONE));  send_byte(8'h55);

    // zero width: rows of a type byte alone
    set_geometry(16'd1, 16'd0, 16'd2);
    send_byte(8'(FILT_PAETH));
    send_byte(8'hFF);

    run_random(RANDOM_ITEMS / 3);

    send_idle_pct = 55;
    recv_idle_pct = 31;

    // height lowered between rows of a tall image
    set_geometry(16'd1, 16'd2, 16'hFFFF);
    repeat (3) send_row(rand_filter(), 2);
    reg_write(CFG_HEIGHT, 16'd3);
    send_row(rand_filter(), 2);

    // width shrunk mid-row, so the next byte closes the row
    set_geometry(16'd1, 16'd10, 16'd2);
    send_byte(8'(FILT_AVG));
    repeat (6) send_byte(rand_data());
    reg_write(CFG_WIDTH, 16'd3);
    send_byte(rand_data());
    send_row(8'(FILT_PAETH), 3);

    run_random(RANDOM_ITEMS / 3);

    send_idle_pct = 0;
    recv_idle_pct = 0;

    // first row grown mid-row
    set_geometry(16'd8, 16'd1, 16'd1);
    send_byte(8'(FILT_SUB));
    repeat (3) send_byte(rand_data());
    reg_write(CFG_WIDTH, 16'd4);
    repeat (32 - 3) send_byte(rand_data());

    // row exactly as long as the line store is accepted, then cut short
    set_geometry(16'd1, 16'd8192, 16'd1);
    send_byte(8'(FILT_UP));
    repeat (6) send_byte(rand_data());
    reg_write(CFG_WIDTH, 16'd4);
    send_byte(rand_data());

    // row too long beats an unknown type byte, then cut short
    set_geometry(16'd1, 16'd16383, 16'd1);
    send_byte(8'hFF);
    repeat (3) send_byte(rand_data());
    reg_write(CFG_WIDTH, 16'd1);
    send_byte(rand_data());

    run_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

    // drain
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (2 * SETTLE_CYCLES) @(posedge clk_i);
    if (err_count == 0 && pending == 0) begin
      $display("png_scanline_unfilter_core_tb: done, clean");
    end else begin
      $display("png_scanline_unfilter_core_tb: done, errors");
    end
    $finish;
  end

endmodule
